@@ design/pwm_duty_frequency_capture_core_defines.svh @@
// Assertion macros for the PWM duty and frequency capture block
`ifndef PWM_DUTY_FREQUENCY_CAPTURE_CORE_DEFINES_SVH
`define PWM_DUTY_FREQUENCY_CAPTURE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PDFC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PDFC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pdfc_pkg.sv @@
// Shared constants and types for the PWM duty and frequency capture block
package pdfc_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int CLOCK_WIDTH       = 27;
    localparam int DUTY_WIDTH        = 7;

    localparam logic [CLOCK_WIDTH-1:0] CLOCK_RESET  = 27'd16000000;
    localparam logic [DUTY_WIDTH-1:0]  PERCENT_FULL = 7'd100;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_FALL   = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/pdfc_if.sv @@
// Handshake channels for capture items, result items and configuration writes
interface pdfc_in_if import pdfc_pkg::*; #(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [COUNTER_WIDTH-1:0] capture_time;

    modport source (output valid, output operation, output capture_time, input ready);
    modport sink   (input valid, input operation, input capture_time, output ready);
endinterface

interface pdfc_out_if import pdfc_pkg::*; #(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [COUNTER_WIDTH-1:0] high_ticks;
    logic [COUNTER_WIDTH-1:0] period_ticks;
    logic [DUTY_WIDTH-1:0]    duty_percent;
    logic [CLOCK_WIDTH-1:0]   frequency_hz;
    logic                     error;

    modport source (output valid, output high_ticks, output period_ticks,
                    output duty_percent, output frequency_hz, output error, input ready);
    modport sink   (input valid, input high_ticks, input period_ticks,
                    input duty_percent, input frequency_hz, input error, output ready);
endinterface

interface pdfc_cfg_if import pdfc_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CLOCK_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/pwm_duty_frequency_capture_core.sv @@
// PWM duty and frequency capture: phase tracking, sequencer and result register
// Sequencing: a closing capture item runs the duty division, then the frequency division,
//   on the shared restoring divider (DW = max(27, COUNTER_WIDTH+7)), one bit per cycle; if
//   high exceeds period only the frequency division runs, and a zero period skips both. The
//   input is not ready until the result is registered; other items are taken while idle.
// Reset: phase to awaiting first rising edge, clock_hz to 16000000, no result pending.
`include "pwm_duty_frequency_capture_core_defines.svh"

module pwm_duty_frequency_capture_core import pdfc_pkg::*; #(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pdfc_cfg_if.sink  cfg,
    pdfc_in_if.sink   capture,
    pdfc_out_if.source result
);

    localparam int DW = (COUNTER_WIDTH + DUTY_WIDTH > CLOCK_WIDTH) ?
                        COUNTER_WIDTH + DUTY_WIDTH : CLOCK_WIDTH;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DUTY_START = 3'd1;
    localparam logic [2:0] S_DUTY_WAIT  = 3'd2;
    localparam logic [2:0] S_FREQ_START = 3'd3;
    localparam logic [2:0] S_FREQ_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE       = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [1:0]               phase_reg, phase_next;
    logic [CLOCK_WIDTH-1:0]   clock_reg, clock_next;
    logic [COUNTER_WIDTH-1:0] first_reg, first_next;
    logic [COUNTER_WIDTH-1:0] second_reg, second_next;
    logic [COUNTER_WIDTH-1:0] high_reg, high_next;
    logic [COUNTER_WIDTH-1:0] period_reg, period_next;
    logic [DUTY_WIDTH-1:0]    duty_reg, duty_next;
    logic [CLOCK_WIDTH-1:0]   freq_reg, freq_next;
    logic                     err_reg, err_next;
    logic                     out_valid_reg, out_valid_next;
    logic [COUNTER_WIDTH-1:0] out_high_reg, out_high_next;
    logic [COUNTER_WIDTH-1:0] out_period_reg, out_period_next;
    logic [DUTY_WIDTH-1:0]    out_duty_reg, out_duty_next;
    logic [CLOCK_WIDTH-1:0]   out_freq_reg, out_freq_next;
    logic                     out_err_reg, out_err_next;

    logic                     in_fire;
    logic                     div_start;
    logic [DW-1:0]            div_dividend;
    div_stat_t                div_stat;
    logic [DW-1:0]            div_quotient;

    assign in_fire     = capture.valid && capture.ready;
    assign capture.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DW'(clock_reg);
        if (state_reg == S_DUTY_START && period_reg != '0 && high_reg <= period_reg)
        begin
            div_start    = 1'b1;
            div_dividend = DW'(high_reg) * DW'(PERCENT_FULL);
        end
        else if (state_reg == S_FREQ_START)
        begin
            div_start = 1'b1;
        end
    end

    pdfc_div #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .DIVIDEND_WIDTH(DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (period_reg),
        .stat    (div_stat),
        .quotient(div_quotient)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        clock_next      = clock_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        high_next       = high_reg;
        period_next     = period_reg;
        duty_next       = duty_reg;
        freq_next       = freq_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_high_next   = out_high_reg;
        out_period_next = out_period_reg;
        out_duty_next   = out_duty_reg;
        out_freq_next   = out_freq_reg;
        out_err_next    = out_err_reg;

        if (cfg.valid)
        begin
            clock_next = cfg.data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (capture.operation == OP_RESTART)
                    begin
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_FIRST:
                            begin
                                first_next = capture.capture_time;
                                phase_next = PH_FALL;
                            end
                            PH_FALL:
                            begin
                                second_next = capture.capture_time;
                                phase_next  = PH_SECOND;
                            end
                            PH_SECOND:
                            begin
                                high_next   = second_reg - first_reg;
                                period_next = capture.capture_time - first_reg;
                                phase_next  = PH_DONE;
                                state_next  = S_DUTY_START;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            S_DUTY_START:
            begin
                if (period_reg == '0)
                begin
                    high_next  = '0;
                    duty_next  = '0;
                    freq_next  = '0;
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (high_reg > period_reg)
                begin
                    duty_next  = PERCENT_FULL;
                    err_next   = 1'b1;
                    state_next = S_FREQ_START;
                end
                else
                begin
                    err_next   = 1'b0;
                    state_next = S_DUTY_WAIT;
                end
            end
            S_DUTY_WAIT:
            begin
                if (div_stat.done)
                begin
                    duty_next  = div_quotient[DUTY_WIDTH-1:0];
                    state_next = S_FREQ_START;
                end
            end
            S_FREQ_START:
            begin
                state_next = S_FREQ_WAIT;
            end
            S_FREQ_WAIT:
            begin
                if (div_stat.done)
                begin
                    freq_next  = div_quotient[CLOCK_WIDTH-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_high_next   = high_reg;
                    out_period_next = period_reg;
                    out_duty_next   = duty_reg;
                    out_freq_next   = freq_reg;
                    out_err_next    = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIRST;
            clock_reg     <= CLOCK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        second_reg     <= second_next;
        high_reg       <= high_next;
        period_reg     <= period_next;
        duty_reg       <= duty_next;
        freq_reg       <= freq_next;
        err_reg        <= err_next;
        out_high_reg   <= out_high_next;
        out_period_reg <= out_period_next;
        out_duty_reg   <= out_duty_next;
        out_freq_reg   <= out_freq_next;
        out_err_reg    <= out_err_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.high_ticks   = out_high_reg;
    assign result.period_ticks = out_period_reg;
    assign result.duty_percent = out_duty_reg;
    assign result.frequency_hz = out_freq_reg;
    assign result.error        = out_err_reg;

    `PDFC_ASSERT_IMPL(a_busy_phase_done, state_reg != S_IDLE, phase_reg == PH_DONE,
        "measurement running outside the done phase")
    `PDFC_ASSERT_IMPL(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE),
        "result raised outside the done state")
    `PDFC_ASSERT_NEXT(a_duty_then_freq, state_reg == S_DUTY_WAIT && div_stat.done,
        state_reg == S_FREQ_START, "frequency division did not follow duty division")
    `PDFC_ASSERT_IMPL(a_div_idle_when_waiting, state_reg == S_IDLE || state_reg == S_DONE,
        !div_stat.busy, "divider running while sequencer is not waiting on it")

endmodule

@@ design/pdfc_div.sv @@
// Restoring divider, one quotient bit per cycle
`include "pwm_duty_frequency_capture_core_defines.svh"

module pdfc_div import pdfc_pkg::*; #(
    parameter int COUNTER_WIDTH  = COUNTER_WIDTH_DEF,
    parameter int DIVIDEND_WIDTH = CLOCK_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [COUNTER_WIDTH-1:0]  divisor,
    output div_stat_t                 stat,
    output logic [DIVIDEND_WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_WIDTH + 1);

    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [COUNTER_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_WIDTH-1:0] quo_reg, quo_next;
    logic [COUNTER_WIDTH-1:0]  dvs_reg, dvs_next;

    logic [COUNTER_WIDTH:0]    rem_shift;
    logic [COUNTER_WIDTH:0]    diff;
    logic                      ge;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (run_reg)
        begin
            rem_next   = ge ? diff[COUNTER_WIDTH-1:0] : rem_shift[COUNTER_WIDTH-1:0];
            quo_next   = {quo_reg[DIVIDEND_WIDTH-2:0], ge};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            run_next   = 1'b1;
            count_next = CNT_W'(DIVIDEND_WIDTH);
            rem_next   = '0;
            quo_next   = dividend;
            dvs_next   = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `PDFC_ASSERT_NEXT(a_start_runs, start && !run_reg, run_reg, "divider did not start")
    `PDFC_ASSERT_NEXT(a_last_step_done, run_reg && count_reg == CNT_W'(1), done_reg && !run_reg,
        "divider did not finish on its last step")
    `PDFC_ASSERT_IMPL(a_done_idle, done_reg, !run_reg, "divider done while still running")

endmodule
